// ===== rtl/core/ftfp_pkg.sv =====
// shared types, constants and codes of the fixed-timestep frame pacer
package ftfp_pkg;

    localparam int TICK_W    = 24;
    localparam int BACKLOG_W = TICK_W + 1;
    localparam int LAG_W     = 16;
    localparam int TOTAL_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = TICK_W;

    localparam int DIV_STEPS = TICK_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [BACKLOG_W-1:0] TICKS_PER_MS = BACKLOG_W'(10000);
    localparam logic [LAG_W-1:0]     SLOW_LAG_SET = LAG_W'(5);
    localparam logic [LAG_W-1:0]     LAG_MAX      = {LAG_W{1'b1}};

    localparam logic              RST_FIXED_MODE  = 1'b1;
    localparam logic [TICK_W-1:0] RST_STEP_PERIOD = TICK_W'(166667);
    localparam logic [TICK_W-1:0] RST_MAX_BACKLOG = TICK_W'(5000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXED_MODE  = 2'd0,
        CFG_STEP_PERIOD = 2'd1,
        CFG_MAX_BACKLOG = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FIN,
        S_LAG,
        S_VAR,
        S_PUBLISH
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_DIV_STEP,
        OP_FIN,
        OP_LAG,
        OP_VAR,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        logic waiting;
        logic fixed;
        logic do_div;
        logic div_last;
    } t_dp_stat;

    typedef struct packed {
        logic [TICK_W-1:0] elapsed;
        logic              exit_request;
        logic              suppress_draw;
    } t_in_item;

    typedef struct packed {
        logic               frame_done;
        logic [TICK_W-1:0]  step_count;
        logic [TICK_W-1:0]  frame_time;
        logic               running_slowly;
        logic               draw_frame;
        logic               stop_running;
        logic [TOTAL_W-1:0] total_time;
    } t_out_item;

endpackage

// ===== rtl/core/fixed_timestep_frame_pacer_unit.sv =====
// top level of the fixed-timestep frame pacer
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+--------------------------
//  input    | i_in_valid / o_in_stall            | i_in_data  (t_in_item)
//  result   | o_out_valid / i_out_stall          | o_out_data (t_out_item)
//  config   | i_cfg_we                           | i_cfg_idx, i_cfg_data
//
// one transaction at a time: a waiting answer goes check, publish; variable mode check,
// var, publish; fixed mode check, the 24-step restoring divider when it divides, fin,
// lag, publish. a new input is taken once the result is registered.
// reset is synchronous, clears the pacing state and loads the default config.
// a stalled result holds; the next transaction runs meanwhile and waits to publish.
module fixed_timestep_frame_pacer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ftfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ftfp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ftfp_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ftfp_pkg::t_out_item            o_out_data
);

    ftfp_pkg::t_op      w_op;
    ftfp_pkg::t_dp_stat w_stat;

    ftfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_op        (w_op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    ftfp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_op       (w_op),
        .i_in_data  (i_in_data),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction was not started");

    a_wait_has_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_done) |->
            (o_out_data.step_count == '0 && o_out_data.frame_time == '0))
        else $error("waiting result carries steps");

    a_draw_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.draw_frame || o_out_data.stop_running)) |->
            o_out_data.frame_done)
        else $error("draw or stop flagged on a waiting result");

endmodule

// ===== rtl/core/ftfp_ctrl.sv =====
// sequencing state machine of the frame pacer
module ftfp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  ftfp_pkg::t_dp_stat i_stat,
    output ftfp_pkg::t_op      o_op,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    ftfp_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_pub_ok;

    assign w_pub_ok = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftfp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ftfp_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ftfp_pkg::S_CHECK;
            end
            ftfp_pkg::S_CHECK: begin
                if (i_stat.waiting)     n_state = ftfp_pkg::S_PUBLISH;
                else if (!i_stat.fixed) n_state = ftfp_pkg::S_VAR;
                else if (i_stat.do_div) n_state = ftfp_pkg::S_DIV;
                else                    n_state = ftfp_pkg::S_FIN;
            end
            ftfp_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = ftfp_pkg::S_FIN;
            end
            ftfp_pkg::S_FIN:     n_state = ftfp_pkg::S_LAG;
            ftfp_pkg::S_LAG:     n_state = ftfp_pkg::S_PUBLISH;
            ftfp_pkg::S_VAR:     n_state = ftfp_pkg::S_PUBLISH;
            ftfp_pkg::S_PUBLISH: begin
                if (w_pub_ok) n_state = ftfp_pkg::S_IDLE;
            end
            default:             n_state = ftfp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op        = ftfp_pkg::OP_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ftfp_pkg::S_IDLE: begin
                if (i_in_valid) o_op = ftfp_pkg::OP_LOAD;
            end
            ftfp_pkg::S_CHECK: o_op = ftfp_pkg::OP_CHECK;
            ftfp_pkg::S_DIV:   o_op = ftfp_pkg::OP_DIV_STEP;
            ftfp_pkg::S_FIN:   o_op = ftfp_pkg::OP_FIN;
            ftfp_pkg::S_LAG:   o_op = ftfp_pkg::OP_LAG;
            ftfp_pkg::S_VAR:   o_op = ftfp_pkg::OP_VAR;
            ftfp_pkg::S_PUBLISH: begin
                if (w_pub_ok) begin
                    o_op        = ftfp_pkg::OP_PUBLISH;
                    n_out_valid = 1'b1;
                end
            end
            default: o_op = ftfp_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_state != ftfp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/ftfp_dp.sv =====
// datapath of the frame pacer: config, backlog, step divider, lag and totals
module ftfp_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ftfp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ftfp_pkg::CFG_W-1:0]         i_cfg_data,
    input  ftfp_pkg::t_op                      i_op,
    input  ftfp_pkg::t_in_item                 i_in_data,
    output ftfp_pkg::t_dp_stat                 o_stat,
    output ftfp_pkg::t_out_item                o_out_data
);

    localparam int TW = ftfp_pkg::TICK_W;
    localparam int BW = ftfp_pkg::BACKLOG_W;
    localparam int LW = ftfp_pkg::LAG_W;

    // config
    logic                          r_fixed;
    logic [TW-1:0]                 r_period;
    logic [TW-1:0]                 r_max;
    // state
    logic [BW-1:0]                 r_backlog;
    logic [ftfp_pkg::TOTAL_W-1:0]  r_total;
    logic [LW-1:0]                 r_lag;
    logic                          r_slow;
    // per transaction
    logic                          r_exit;
    logic                          r_supp;
    logic                          r_done;
    logic [TW-1:0]                 r_steps;
    logic [TW-1:0]                 r_ftime;
    logic [TW-1:0]                 r_quot;
    logic [BW-1:0]                 r_rem;
    logic [ftfp_pkg::CNT_W-1:0]    r_cnt;
    ftfp_pkg::t_out_item           r_out;

    logic [BW:0]   w_diff;
    logic          w_waiting;
    logic [BW-1:0] w_clamped;
    logic [BW-1:0] w_trial;
    logic          w_ge;
    logic [TW-1:0] w_extra;
    logic [BW-1:0] w_lag_sum;
    logic [LW-1:0] w_lag_sat;

    // in fixed mode, wait when the backlog is a millisecond or more short of one step
    assign w_diff    = {2'b00, r_period} - {1'b0, r_backlog};
    assign w_waiting = r_fixed && !w_diff[BW] && (w_diff[BW-1:0] >= ftfp_pkg::TICKS_PER_MS);
    assign w_clamped = (r_backlog > {1'b0, r_max}) ? {1'b0, r_max} : r_backlog;

    // one restoring division step
    assign w_trial = {r_rem[TW-1:0], r_quot[TW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_period});

    assign w_extra   = (r_quot == '0) ? '0 : r_quot - TW'(1);
    assign w_lag_sum = {1'b0, w_extra} + BW'(r_lag);
    assign w_lag_sat = (w_lag_sum > BW'(ftfp_pkg::LAG_MAX)) ? ftfp_pkg::LAG_MAX
                                                            : w_lag_sum[LW-1:0];

    assign o_stat.waiting  = w_waiting;
    assign o_stat.fixed    = r_fixed;
    assign o_stat.do_div   = !r_exit && (r_period != '0);
    assign o_stat.div_last = (r_cnt == ftfp_pkg::CNT_W'(ftfp_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed  <= ftfp_pkg::RST_FIXED_MODE;
            r_period <= ftfp_pkg::RST_STEP_PERIOD;
            r_max    <= ftfp_pkg::RST_MAX_BACKLOG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ftfp_pkg::CFG_FIXED_MODE:  r_fixed  <= i_cfg_data[0];
                ftfp_pkg::CFG_STEP_PERIOD: r_period <= i_cfg_data;
                ftfp_pkg::CFG_MAX_BACKLOG: r_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlog <= '0;
            r_total   <= '0;
            r_lag     <= '0;
            r_slow    <= 1'b0;
            r_cnt     <= '0;
        end else begin
            case (i_op)
                ftfp_pkg::OP_LOAD: begin
                    r_backlog <= r_backlog + BW'(i_in_data.elapsed);
                end
                ftfp_pkg::OP_CHECK: begin
                    if (!w_waiting) r_backlog <= w_clamped;
                    r_cnt <= '0;
                end
                ftfp_pkg::OP_DIV_STEP: begin
                    r_cnt <= r_cnt + ftfp_pkg::CNT_W'(1);
                end
                ftfp_pkg::OP_FIN: begin
                    r_backlog <= r_rem;
                    r_lag     <= w_lag_sat;
                end
                ftfp_pkg::OP_LAG: begin
                    r_total <= r_total + ftfp_pkg::TOTAL_W'(r_ftime);
                    if (r_slow) begin
                        if (r_lag == '0) r_slow <= 1'b0;
                    end else if (r_lag >= ftfp_pkg::SLOW_LAG_SET) begin
                        r_slow <= 1'b1;
                    end
                    if (r_steps == TW'(1) && r_lag != '0) r_lag <= r_lag - LW'(1);
                end
                ftfp_pkg::OP_VAR: begin
                    r_total   <= r_total + ftfp_pkg::TOTAL_W'(r_backlog);
                    r_backlog <= '0;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            ftfp_pkg::OP_LOAD: begin
                r_exit <= i_in_data.exit_request;
                r_supp <= i_in_data.suppress_draw;
            end
            ftfp_pkg::OP_CHECK: begin
                r_done  <= !w_waiting;
                r_steps <= '0;
                r_ftime <= '0;
                // without division the quotient is zero and the backlog stays
                if (r_exit || r_period == '0) begin
                    r_quot <= '0;
                    r_rem  <= w_clamped;
                end else begin
                    r_quot <= w_clamped[TW-1:0];
                    r_rem  <= '0;
                end
            end
            ftfp_pkg::OP_DIV_STEP: begin
                r_rem  <= w_ge ? w_trial - {1'b0, r_period} : w_trial;
                r_quot <= {r_quot[TW-2:0], w_ge};
            end
            ftfp_pkg::OP_FIN: begin
                r_steps <= r_quot;
                r_ftime <= r_backlog[TW-1:0] - r_rem[TW-1:0];
            end
            ftfp_pkg::OP_VAR: begin
                r_steps <= TW'(1);
                r_ftime <= r_backlog[TW-1:0];
            end
            ftfp_pkg::OP_PUBLISH: begin
                r_out.frame_done     <= r_done;
                r_out.step_count     <= r_steps;
                r_out.frame_time     <= r_ftime;
                r_out.running_slowly <= r_slow;
                r_out.draw_frame     <= r_done && !r_supp;
                r_out.stop_running   <= r_done && r_exit;
                r_out.total_time     <= r_total;
            end
            default: ;
        endcase
    end

    assign o_out_data = r_out;

endmodule

// ===== bench/fixed_timestep_frame_pacer_unit_tb.sv =====
// self-checking testbench of the fixed-timestep frame pacer: table, random pacing, table tail
module fixed_timestep_frame_pacer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MS_TICKS      = 10000;
    localparam int unsigned LAG_SET_LEVEL = 5;
    localparam int unsigned LAG_CEIL      = 65535;
    localparam int unsigned BACKLOG_MASK  = 32'h1FF_FFFF;
    localparam logic [23:0] TICK_MAX      = 24'hFF_FFFF;
    localparam int          RAND_PHASES   = 8;
    localparam int          PHASE_FRAMES  = 200;
    localparam int          HOLD_AFTER    = 300;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          PHASE_SETTLE  = 4;
    localparam int          END_SETTLE    = 40;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [ftfp_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [ftfp_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    ftfp_pkg::t_in_item             i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    ftfp_pkg::t_out_item            o_out_data;

    fixed_timestep_frame_pacer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // pacing state and registers as the block should hold them
    logic        cfg_fixed   = 1'b1;
    logic [23:0] cfg_period  = 24'd166667;
    logic [23:0] cfg_max     = 24'd5000000;
    logic [24:0] backlog_q   = '0;
    logic [63:0] game_time_q = '0;
    logic [15:0] lag_q       = '0;
    logic        slow_q      = 1'b0;

    ftfp_pkg::t_out_item due_results[$];
    int                  mismatches   = 0;
    int                  results_seen = 0;
    int                  quiet_left   = 0;

    typedef struct {
        bit                         is_cfg;
        ftfp_pkg::t_cfg_idx         idx;
        logic [ftfp_pkg::CFG_W-1:0] val;
        ftfp_pkg::t_in_item         frame;
        bit                         has_gold;
        ftfp_pkg::t_out_item        gold;
    } t_vec;

    t_vec vec_q[$];
    int   tail_start;

    function automatic ftfp_pkg::t_out_item pace_frame(input ftfp_pkg::t_in_item frame);
        ftfp_pkg::t_out_item res;
        int unsigned         bl;
        int unsigned         steps;
        int unsigned         ftime;
        int unsigned         extra;
        res   = '0;
        steps = 0;
        ftime = 0;
        bl    = (32'(backlog_q) + 32'(frame.elapsed)) & BACKLOG_MASK;
        // fixed mode, still a millisecond or more short of a step: only the backlog moves
        if (cfg_fixed && bl < 32'(cfg_period) && 32'(cfg_period) - bl >= MS_TICKS) begin
            backlog_q          = 25'(bl);
            res.running_slowly = slow_q;
            res.total_time     = game_time_q;
            return res;
        end
        if (bl > 32'(cfg_max))
            bl = 32'(cfg_max);
        if (cfg_fixed) begin
            if (!frame.exit_request && cfg_period != 0) begin
                steps       = bl / 32'(cfg_period);
                ftime       = steps * 32'(cfg_period);
                bl          = bl - ftime;
                game_time_q = game_time_q + 64'(ftime);
            end
            extra = (steps > 0) ? steps - 1 : 0;
            if (extra > LAG_CEIL - 32'(lag_q))
                lag_q = 16'(LAG_CEIL);
            else
                lag_q = lag_q + 16'(extra);
            // hysteresis on the slow flag
            if (slow_q) begin
                if (lag_q == 0)
                    slow_q = 1'b0;
            end else if (32'(lag_q) >= LAG_SET_LEVEL) begin
                slow_q = 1'b1;
            end
            if (steps == 1 && lag_q > 0)
                lag_q = lag_q - 16'd1;
        end else begin
            steps       = 1;
            ftime       = bl;
            game_time_q = game_time_q + 64'(bl);
            bl          = 0;
        end
        backlog_q          = 25'(bl);
        res.frame_done     = 1'b1;
        res.step_count     = 24'(steps);
        res.frame_time     = 24'(ftime);
        res.running_slowly = slow_q;
        res.draw_frame     = !frame.suppress_draw;
        res.stop_running   = frame.exit_request;
        res.total_time     = game_time_q;
        return res;
    endfunction

    function automatic ftfp_pkg::t_out_item outcome(input bit done, input logic [23:0] steps,
                                                    input logic [23:0] ftime, input bit slow,
                                                    input bit draw, input bit stop,
                                                    input logic [63:0] total);
        ftfp_pkg::t_out_item res;
        res.frame_done     = done;
        res.step_count     = steps;
        res.frame_time     = ftime;
        res.running_slowly = slow;
        res.draw_frame     = draw;
        res.stop_running   = stop;
        res.total_time     = total;
        return res;
    endfunction

    function automatic void add_frame(input logic [23:0] el, input bit ex, input bit sup,
                                      input bit has_gold = 1'b0,
                                      input ftfp_pkg::t_out_item gold = '0);
        t_vec v;
        v.is_cfg              = 1'b0;
        v.idx                 = ftfp_pkg::CFG_FIXED_MODE;
        v.val                 = '0;
        v.frame.elapsed       = el;
        v.frame.exit_request  = ex;
        v.frame.suppress_draw = sup;
        v.has_gold            = has_gold;
        v.gold                = gold;
        vec_q.push_back(v);
    endfunction

    function automatic void add_cfg(input ftfp_pkg::t_cfg_idx idx,
                                    input logic [ftfp_pkg::CFG_W-1:0] val);
        t_vec v;
        v.is_cfg   = 1'b1;
        v.idx      = idx;
        v.val      = val;
        v.frame    = '0;
        v.has_gold = 1'b0;
        v.gold     = '0;
        vec_q.push_back(v);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // sender gap, with the odd back-to-back stretch
    function automatic int next_gap();
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
            quiet_left = $urandom_range(10, 40);
        return idle_len();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR: %0t ns result %0d %s: got %0h expected %0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_frame(input ftfp_pkg::t_in_item frame, input bit has_gold,
                              input ftfp_pkg::t_out_item gold);
        ftfp_pkg::t_out_item want;
        int                  gap;
        i_in_data  <= frame;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        want = pace_frame(frame);
        due_results.push_back(has_gold ? gold : want);
        gap = next_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input ftfp_pkg::t_cfg_idx idx,
                             input logic [ftfp_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            ftfp_pkg::CFG_FIXED_MODE:  cfg_fixed  = val[0];
            ftfp_pkg::CFG_STEP_PERIOD: cfg_period = val;
            ftfp_pkg::CFG_MAX_BACKLOG: cfg_max    = val;
            default: ;
        endcase
    endtask

    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic walk_table(input int lo, input int hi);
        bit cfg_open;
        cfg_open = 1'b0;
        for (int k = lo; k < hi; k++) begin
            if (vec_q[k].is_cfg) begin
                if (!cfg_open)
                    drain(PHASE_SETTLE);
                write_reg(vec_q[k].idx, vec_q[k].val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open)
                    i_cfg_we <= 1'b0;
                cfg_open = 1'b0;
                send_frame(vec_q[k].frame, vec_q[k].has_gold, vec_q[k].gold);
            end
        end
        if (cfg_open)
            i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        ftfp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing expected", 64'd1, 64'd0);
            end else begin
                want = due_results.pop_front();
                if (o_out_data.frame_done !== want.frame_done)
                    report_mismatch("frame_done", 64'(o_out_data.frame_done),
                                    64'(want.frame_done));
                if (o_out_data.step_count !== want.step_count)
                    report_mismatch("step_count", 64'(o_out_data.step_count),
                                    64'(want.step_count));
                if (o_out_data.frame_time !== want.frame_time)
                    report_mismatch("frame_time", 64'(o_out_data.frame_time),
                                    64'(want.frame_time));
                if (o_out_data.running_slowly !== want.running_slowly)
                    report_mismatch("running_slowly", 64'(o_out_data.running_slowly),
                                    64'(want.running_slowly));
                if (o_out_data.draw_frame !== want.draw_frame)
                    report_mismatch("draw_frame", 64'(o_out_data.draw_frame),
                                    64'(want.draw_frame));
                if (o_out_data.stop_running !== want.stop_running)
                    report_mismatch("stop_running", 64'(o_out_data.stop_running),
                                    64'(want.stop_running));
                if (o_out_data.total_time !== want.total_time)
                    report_mismatch("total_time", o_out_data.total_time, want.total_time);
            end
        end
    end

    // result side back-pressure, with one long hold-off to fill the block
    initial begin
        int n;
        bit held;
        held = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 15) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(30, 150)) @(posedge i_clk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int                  ph;
        int                  n;
        int                  r;
        logic                fixed;
        logic [23:0]         period;
        logic [23:0]         cap;
        longint unsigned     el;
        ftfp_pkg::t_in_item  fr;

        // default registers from reset
        add_frame(24'd0, 1'b0, 1'b0, 1'b1,
                  outcome(1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 64'd0));
        add_frame(24'd166667, 1'b0, 1'b0, 1'b1,
                  outcome(1'b1, 24'd1, 24'd166667, 1'b0, 1'b1, 1'b0, 64'd166667));
        // exactly one millisecond short still waits
        add_frame(24'd156667, 1'b0, 1'b1, 1'b1,
                  outcome(1'b0, 24'd0, 24'd0, 1'b0, 1'b0, 1'b0, 64'd166667));
        // just inside the millisecond: processed without a step
        add_frame(24'd1, 1'b0, 1'b0, 1'b1,
                  outcome(1'b1, 24'd0, 24'd0, 1'b0, 1'b1, 1'b0, 64'd166667));
        // exit keeps the clamped backlog
        add_frame(TICK_MAX, 1'b1, 1'b1, 1'b1,
                  outcome(1'b1, 24'd0, 24'd0, 1'b0, 1'b0, 1'b1, 64'd166667));
        add_frame(24'd0, 1'b0, 1'b0);
        add_frame(24'd10, 1'b0, 1'b0);
        add_frame(TICK_MAX, 1'b0, 1'b0);
        add_cfg(ftfp_pkg::CFG_STEP_PERIOD, 24'd0);
        add_frame(24'd12345, 1'b0, 1'b1);
        add_cfg(ftfp_pkg::CFG_MAX_BACKLOG, 24'd0);
        add_frame(TICK_MAX, 1'b0, 1'b0);
        add_cfg(ftfp_pkg::CFG_FIXED_MODE, 24'hFF_FFFE);
        add_frame(TICK_MAX, 1'b0, 1'b0);
        add_cfg(ftfp_pkg::CFG_MAX_BACKLOG, TICK_MAX);
        add_frame(TICK_MAX, 1'b1, 1'b0);
        add_frame(24'd0, 1'b0, 1'b1);
        add_cfg(ftfp_pkg::CFG_FIXED_MODE, 24'h00_0001);
        add_cfg(ftfp_pkg::CFG_STEP_PERIOD, TICK_MAX);
        add_frame(TICK_MAX, 1'b0, 1'b0);
        add_frame(24'd16767215, 1'b0, 1'b0);
        add_frame(24'd1, 1'b0, 1'b0);
        // lag saturation runs last, nothing unwinds it
        tail_start = vec_q.size();
        add_cfg(ftfp_pkg::CFG_STEP_PERIOD, 24'd1);
        add_cfg(ftfp_pkg::CFG_MAX_BACKLOG, TICK_MAX);
        add_frame(TICK_MAX, 1'b0, 1'b0);
        add_frame(TICK_MAX, 1'b0, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        walk_table(0, tail_start);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain(PHASE_SETTLE);
            if (ph == 0) begin
                fixed  = 1'b1;
                period = 24'd166667;
                cap    = 24'd5000000;
            end else begin
                fixed = (ph == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
                r = $urandom_range(0, 9);
                if (r < 2)
                    period = 24'($urandom_range(1, 64));
                else if (r < 8)
                    period = 24'($urandom_range(10000, 400000));
                else if (r == 8)
                    period = 24'($urandom_range(1000000, 16777215));
                else
                    period = TICK_MAX;
                // keep the backlog to a dozen steps or so, so the lag can come back down
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    cap = 24'($urandom_range(1, 32'(period)));
                end else if (r == 1 && period >= 24'd1000000) begin
                    cap = TICK_MAX;
                end else begin
                    el  = 64'(period) * 64'($urandom_range(1, 12));
                    cap = (el > 64'(TICK_MAX)) ? TICK_MAX : el[23:0];
                end
            end
            write_reg(ftfp_pkg::CFG_FIXED_MODE, {23'($urandom), fixed});
            write_reg(ftfp_pkg::CFG_STEP_PERIOD, period);
            write_reg(ftfp_pkg::CFG_MAX_BACKLOG, cap);
            i_cfg_we <= 1'b0;

            for (n = 0; n < PHASE_FRAMES; n++) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    el = 64'(cfg_period) * 64'($urandom_range(30, 130)) / 64'd100;
                else if (r < 70)
                    el = 64'(cfg_period) * 64'($urandom_range(2, 8));
                else if (r < 80)
                    el = 64'($urandom & 32'hFF_FFFF);
                else if (r < 92)
                    el = 64'($urandom_range(0, 20000));
                else if (r < 96)
                    el = 64'd0;
                else
                    el = 64'(TICK_MAX);
                if (el > 64'(TICK_MAX))
                    el = 64'(TICK_MAX);
                fr.elapsed       = el[23:0];
                fr.exit_request  = ($urandom_range(0, 19) == 0);
                fr.suppress_draw = ($urandom_range(0, 1) != 0);
                send_frame(fr, 1'b0, '0);
            end
        end

        walk_table(tail_start, vec_q.size());
        drain(END_SETTLE);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #10ms;
        $display("ERROR: timeout with %0d results still due", due_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ftfp_pkg.sv
rtl/core/ftfp_ctrl.sv
rtl/core/ftfp_dp.sv
rtl/core/fixed_timestep_frame_pacer_unit.sv
bench/fixed_timestep_frame_pacer_unit_tb.sv
